[design/ntbp_pkg.sv]
// shared types, constants and helpers of the two-bit nucleotide packer
package ntbp_pkg;

  localparam int POSITION_WIDTH = 32;
  localparam int NPOS_W         = 32;
  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QCNT_W         = $clog2(QDEPTH + 1);

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_NSITE = 1'b1;

  localparam logic [1:0] LAST_SLOT = 2'd3;

  // one queue entry: what a single accepted base asks the back end to send
  typedef struct packed {
    logic                      has_n;
    logic [POSITION_WIDTH-1:0] n_pos;
    logic                      has_byte;
    logic [7:0]                byte_val;
    logic                      last;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // bit 2 set for a non-ACGT character, low bits carry the 2-bit code
  function automatic logic [2:0] base_code(input logic [7:0] ch);
    logic [2:0] c;
    unique case (ch)
      8'h41, 8'h61: c = 3'b000;
      8'h43, 8'h63: c = 3'b001;
      8'h47, 8'h67: c = 3'b010;
      8'h54, 8'h74: c = 3'b011;
      default:      c = 3'b100;
    endcase
    return c;
  endfunction

endpackage

[design/ntbp_if.sv]
// valid/ready channel interfaces for bases in and results out
interface ntbp_in_if import ntbp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] base_char;
  logic       read_end;

  modport source (output valid, output base_char, output read_end, input ready);
  modport sink   (input valid, input base_char, input read_end, output ready);
endinterface

interface ntbp_out_if import ntbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [7:0]        packed_byte;
  logic [NPOS_W-1:0] n_position;
  logic              end_of_read;

  modport source (output valid, output kind, output packed_byte, output n_position,
                  output end_of_read, input ready);
  modport sink   (input valid, input kind, input packed_byte, input n_position,
                  input end_of_read, output ready);
endinterface

[design/ntbp_front.sv]
// front end: classifies each base, packs codes and queues the work it causes
module ntbp_front import ntbp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [7:0] in_base_char,
  input  logic     in_read_end,
  input  q_stat_t  q_stat,
  output logic     q_push,
  output q_entry_t q_wdata
);

  logic [POSITION_WIDTH-1:0] pos_r;
  logic [7:0]                partial_r;
  logic [1:0]                slot_r;

  logic [2:0] code;
  logic [7:0] byte_nxt;
  logic       emit_byte;
  logic       accept;

  assign in_ready  = !q_stat.full;
  assign accept    = in_valid && in_ready;
  assign code      = base_code(in_base_char);
  // slot k lands at bit 6-2k, i.e. shift by 2*(3-k)
  assign byte_nxt  = partial_r | (8'(code[1:0]) << {~slot_r, 1'b0});
  assign emit_byte = (slot_r == LAST_SLOT) || in_read_end;

  assign q_wdata.has_n    = code[2];
  assign q_wdata.n_pos    = pos_r;
  assign q_wdata.has_byte = emit_byte;
  assign q_wdata.byte_val = byte_nxt;
  assign q_wdata.last     = in_read_end;
  assign q_push           = accept && (code[2] || emit_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      partial_r <= '0;
      slot_r    <= '0;
    end else if (accept) begin
      partial_r <= emit_byte ? 8'h00 : byte_nxt;
      slot_r    <= in_read_end ? 2'd0 : slot_r + 2'd1;
      pos_r     <= in_read_end ? '0 : pos_r + POSITION_WIDTH'(1);
    end
  end

endmodule

[design/ntbp_queue.sv]
// small register queue between the front and back ends
module ntbp_queue import ntbp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wdata,
  input  logic     pop,
  output q_entry_t rdata,
  output q_stat_t  stat
);

  q_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign rdata      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + QCNT_W'(1);
      else if (pop && !push) count_r <= count_r - QCNT_W'(1);
    end
  end

endmodule

[design/ntbp_back.sv]
// back end: turns queued work into one or two result beats, registered output
module ntbp_back import ntbp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  q_entry_t          q_rdata,
  input  q_stat_t           q_stat,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [7:0]        out_packed_byte,
  output logic [NPOS_W-1:0] out_n_position,
  output logic              out_end_of_read
);

  logic              valid_r;
  logic              n_done_r;
  logic              kind_r;
  logic [7:0]        byte_r;
  logic [NPOS_W-1:0] npos_r;
  logic              eor_r;

  logic load;
  logic send_n;

  assign load   = !q_stat.empty && (!valid_r || out_ready);
  assign send_n = q_rdata.has_n && !n_done_r;
  // the entry retires with its last beat
  assign q_pop  = load && (!send_n || !q_rdata.has_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      n_done_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r  <= 1'b1;
        n_done_r <= send_n && q_rdata.has_byte;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (send_n) begin
        kind_r <= KIND_NSITE;
        byte_r <= 8'h00;
        npos_r <= NPOS_W'(q_rdata.n_pos);
        eor_r  <= q_rdata.last && !q_rdata.has_byte;
      end else begin
        kind_r <= KIND_BYTE;
        byte_r <= q_rdata.byte_val;
        npos_r <= '0;
        eor_r  <= q_rdata.last;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = kind_r;
  assign out_packed_byte = byte_r;
  assign out_n_position  = npos_r;
  assign out_end_of_read = eor_r;

endmodule

[design/nucleotide_two_bit_packer_core.sv]
// top level of the two-bit nucleotide packer
// Bases of a read enter one ASCII character per beat on in_ch; A, C, G and T
// in either case pack as codes 0..3, four to a byte with the first base in
// bits 7:6, and any other character packs as code 0 and also yields an
// n-site beat carrying its zero-based position in the read. The input takes
// one base per cycle while the queue has room; the front end is
// combinational, so a base's work is written into the queue on the same edge
// that accepts it, and the back end loads the output register from the queue
// whenever that register is free or being drained. Most bases cause no result
// or one result; a non-ACGT base that also closes a byte causes two beats, and
// the output register sends one beat per cycle while out_ch.ready is high, so
// the sustained rate is one base per cycle as long as results average at most
// one per base. A four-entry queue between the front and back ends soaks up
// bursts of two-beat bases and output stalls before in_ch.ready drops.
module nucleotide_two_bit_packer_core import ntbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ntbp_in_if.sink     in_ch,
  ntbp_out_if.source  out_ch
);

  // queue hookup between front and back
  q_entry_t q_wdata;
  q_entry_t q_rdata;
  q_stat_t  q_stat;
  logic     q_push;
  logic     q_pop;

  // front: classify the base, advance position and slot, queue the beats
  ntbp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_base_char (in_ch.base_char),
    .in_read_end  (in_ch.read_end),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  // decoupling queue
  ntbp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // back: n-site beat first, then the byte beat, through the output register
  ntbp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_rdata         (q_rdata),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_kind        (out_ch.kind),
    .out_packed_byte (out_ch.packed_byte),
    .out_n_position  (out_ch.n_position),
    .out_end_of_read (out_ch.end_of_read)
  );

endmodule

[tb/nucleotide_two_bit_packer_core_tb.sv]
// self-checking testbench of the two-bit nucleotide packer top level
`timescale 1ns / 1ps

module nucleotide_two_bit_packer_core_tb;
  import ntbp_pkg::*;

  // 2-bit codes of the four bases; a wider value marks a non-ACGT character
  localparam logic [2:0] CODE_A   = 3'd0;
  localparam logic [2:0] CODE_C   = 3'd1;
  localparam logic [2:0] CODE_G   = 3'd2;
  localparam logic [2:0] CODE_T   = 3'd3;
  localparam logic [2:0] CODE_BAD = 3'd4;

  localparam int BASE_TARGET    = 1600;
  // longest quiet stretch: source gap (60) plus sink stall (60) plus latency, many times over
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct {
    logic              kind;
    logic [7:0]        packed_byte;
    logic [NPOS_W-1:0] n_position;
    logic              end_of_read;
  } pack_result_t;

  bit   clk;
  logic rst_n;

  ntbp_in_if  in_ch ();
  ntbp_out_if out_ch ();

  nucleotide_two_bit_packer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: mirrors the packer's position, byte under assembly and slot
  logic [POSITION_WIDTH-1:0] read_pos;
  logic [7:0]                byte_acc;
  logic [1:0]                slot_idx;
  pack_result_t              results_due[$];

  bit src_idle;
  bit sink_idle;

  int mismatches;
  int reads_sent;
  int bases_sent;
  int bytes_checked;
  int nsites_checked;
  int quiet_cycles;

  function automatic logic [2:0] acgt_code(input logic [7:0] ch);
    case (ch)
      "A", "a": return CODE_A;
      "C", "c": return CODE_C;
      "G", "g": return CODE_G;
      "T", "t": return CODE_T;
      default:  return CODE_BAD;
    endcase
  endfunction

  // work out the beats one accepted base causes and queue them in order
  function automatic void pack_base(input logic [7:0] ch, input logic last);
    logic [2:0]   code;
    pack_result_t r;
    code = acgt_code(ch);
    if (code == CODE_BAD) begin
      r.kind        = KIND_NSITE;
      r.packed_byte = 8'h00;
      r.n_position  = NPOS_W'(read_pos);
      r.end_of_read = 1'b0;
      results_due.push_back(r);
      code = CODE_A;
    end
    byte_acc = byte_acc | (8'(code[1:0]) << (6 - 2 * slot_idx));
    if (slot_idx == LAST_SLOT || last) begin
      r.kind        = KIND_BYTE;
      r.packed_byte = byte_acc;
      r.n_position  = '0;
      r.end_of_read = last;
      results_due.push_back(r);
      byte_acc = 8'h00;
      slot_idx = 2'd0;
    end else begin
      slot_idx = slot_idx + 2'd1;
    end
    if (last) begin
      read_pos = '0;
      byte_acc = 8'h00;
      slot_idx = 2'd0;
    end else begin
      read_pos = read_pos + 1'b1;
    end
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // send one base; valid stays high into the next call when no gap is drawn
  task automatic send_base(input logic [7:0] ch, input logic last);
    int gap;
    gap = pick_gap(src_idle);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.base_char <= ch;
    in_ch.read_end  <= last;
    do @(posedge clk); while (!in_ch.ready);
    pack_base(ch, last);
    bases_sent++;
    if (last) reads_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_base(s[i], i == s.len() - 1);
  endtask

  // one random read; n_pct is the share of arbitrary bytes among the bases
  task automatic send_random_read(input int len, input int n_pct);
    string      acgt;
    logic [7:0] ch;
    acgt = "ACGTacgt";
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < n_pct) ch = 8'($urandom_range(0, 255));
      else ch = acgt[$urandom_range(0, 7)];
      send_base(ch, i == len - 1);
    end
  endtask

  // each base letter in both cases; full bytes that close on the read end
  task automatic test_base_codes;
    send_string("ACGT");
    send_string("tgca");
  endtask

  // non-ACGT characters at the byte extremes and common ambiguity letters
  task automatic test_nsites;
    send_base(8'h00, 1'b0);
    send_base("N", 1'b0);
    send_base(8'hFF, 1'b0);
    send_base("n", 1'b0);
    send_base("B", 1'b0);
    send_base("G", 1'b1);
  endtask

  // reads of a single base, plain and non-ACGT
  task automatic test_single_base;
    send_string("T");
    send_base(8'hFF, 1'b1);
  endtask

  // n-site beat ahead of a byte beat, mid-read and on the final base
  task automatic test_two_beat_bases;
    send_string("ACGX*");
  endtask

  // short tail byte with unused low bits zero
  task automatic test_partial_tail;
    send_string("GGc");
  endtask

  // random reads until the base target is reached
  task automatic test_random_reads;
    int len;
    int n_pct;
    int r;
    while (bases_sent < BASE_TARGET) begin
      r = $urandom_range(0, 99);
      src_idle  = (r >= 15);
      sink_idle = (r >= 15);
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 12);
      else if (r < 92) len = $urandom_range(13, 64);
      else len = $urandom_range(65, 300);
      r = $urandom_range(0, 99);
      if (r < 70) n_pct = 5;
      else if (r < 90) n_pct = 30;
      else n_pct = 100;
      send_random_read(len, n_pct);
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  // result sink: ready bursts broken by stalls of random length
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = pick_gap(sink_idle);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // compare each accepted result beat with the oldest queued prediction
  always @(posedge clk) begin
    pack_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("beat with nothing queued, kind", 64'(out_ch.kind), 64'h0);
      end else begin
        want = results_due.pop_front();
        if (out_ch.kind !== want.kind)
          report_mismatch("kind", 64'(out_ch.kind), 64'(want.kind));
        if (out_ch.packed_byte !== want.packed_byte)
          report_mismatch("packed_byte", 64'(out_ch.packed_byte), 64'(want.packed_byte));
        if (out_ch.n_position !== want.n_position)
          report_mismatch("n_position", 64'(out_ch.n_position), 64'(want.n_position));
        if (out_ch.end_of_read !== want.end_of_read)
          report_mismatch("end_of_read", 64'(out_ch.end_of_read), 64'(want.end_of_read));
        if (want.kind == KIND_NSITE) nsites_checked++;
        else bytes_checked++;
      end
    end
  end

  // watchdog on cycles where neither channel moves a beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("[%0t] timeout: no beat for %0d cycles, %0d results still queued",
                 $time, WATCHDOG_LIMIT, results_due.size());
        $display("nucleotide_two_bit_packer_core_tb failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.base_char <= 8'h00;
    in_ch.read_end  <= 1'b0;
    read_pos  = '0;
    byte_acc  = 8'h00;
    slot_idx  = 2'd0;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_base_codes;
    test_nsites;
    test_single_base;
    test_two_beat_bases;
    test_partial_tail;
    test_random_reads;

    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d reads, %0d bases: %0d packed bytes and %0d n-site beats checked",
             reads_sent, bases_sent, bytes_checked, nsites_checked);
    $display("field mismatches and stray beats: %0d", mismatches);
    if (mismatches == 0) begin
      $display("nucleotide_two_bit_packer_core_tb passed");
    end else begin
      $display("nucleotide_two_bit_packer_core_tb failed");
    end
    $finish;
  end

endmodule
